// ===== sv/ttt_pkg.sv =====
// ---------------------------------------------------------------------------
// Turn timer table package
// Field widths, default sizes and the operation and result codes shared by
// the channel interfaces and the timer table.
// ---------------------------------------------------------------------------
`default_nettype none

package ttt_pkg;

    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 8;
    localparam int UNIT_W   = 8;
    localparam int HANDLE_W = 16;
    localparam int KIND_W   = 3;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int UNIT_BITS_DEF   = 8;
    localparam int HANDLE_BITS_DEF = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_TURN  = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ISSUED = 3'd0,
        KIND_FULL   = 3'd1,
        KIND_ANSWER = 3'd2,
        KIND_FIRED  = 3'd3,
        KIND_DONE   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== sv/ttt_if.sv =====
// ---------------------------------------------------------------------------
// Turn timer table channels
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface ttt_cmd_if;
    import ttt_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [COUNT_W-1:0]  turn_count;
    logic [UNIT_W-1:0]   unit_id;
    logic                loop_flag;
    logic                fire_at_start;
    logic [HANDLE_W-1:0] timer_id;
    logic [UNIT_W-1:0]   previous_unit;
    logic [UNIT_W-1:0]   next_unit;

    modport source (
        output valid, mode, turn_count, unit_id, loop_flag, fire_at_start,
               timer_id, previous_unit, next_unit,
        input  ready
    );
    modport sink (
        input  valid, mode, turn_count, unit_id, loop_flag, fire_at_start,
               timer_id, previous_unit, next_unit,
        output ready
    );
endinterface

interface ttt_res_if;
    import ttt_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle_id;
    logic [UNIT_W-1:0]   fired_unit;
    logic                active;
    logic                last;

    modport source (
        output valid, kind, handle_id, fired_unit, active, last,
        input  ready
    );
    modport sink (
        input  valid, kind, handle_id, fired_unit, active, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/turn_timer_table_top.sv =====
// ---------------------------------------------------------------------------
// Turn timer table
// A table of turn-counting timers bound to unit ids. Set, clear, query and
// next-turn commands walk the table one slot per cycle while not stalled.
//
// Each command item is taken in the idle state, then walks the table in the
// scan state, one slot per step while the table memory is read at the
// slot address, and posts the final result in the finishing state. Every
// fired timer result or final result that finds the result register still
// occupied holds the walk or the finishing step until it is taken. The block
// takes no new command until the final result of the previous one is posted.
// A result waiting to be taken does not hold off the next command.
// ---------------------------------------------------------------------------
`default_nettype none

module turn_timer_table_top #(
    parameter int TIMER_SLOTS = ttt_pkg::TIMER_SLOTS_DEF,
    parameter int UNIT_BITS   = ttt_pkg::UNIT_BITS_DEF,
    parameter int HANDLE_BITS = ttt_pkg::HANDLE_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ttt_cmd_if.sink   cmd,
    ttt_res_if.source res
);
    import ttt_pkg::*;

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [UNIT_BITS-1:0]   unit;
        logic [COUNT_W-1:0]     period;
        logic [COUNT_W-1:0]     left;
        logic                   looping;
        logic                   at_start;
    } entry_t;

    entry_t mem [TIMER_SLOTS];
    entry_t rdata_reg;
    entry_t wdata;
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [IDX_W-1:0]       raddr;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [TIMER_SLOTS-1:0] vld_reg, vld_next;
    logic [HANDLE_BITS-1:0] counter_reg, counter_next;

    mode_t                  mode_reg, mode_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [UNIT_BITS-1:0]   unit_reg, unit_next;
    logic                   loop_reg, loop_next;
    logic                   at_start_reg, at_start_next;
    logic [HANDLE_W-1:0]    tid_reg, tid_next;
    logic [UNIT_BITS-1:0]   prev_reg, prev_next;
    logic [UNIT_BITS-1:0]   nxt_reg, nxt_next;

    logic                   out_valid_reg, out_valid_next;
    kind_t                  out_kind_reg, out_kind_next;
    logic [HANDLE_W-1:0]    out_handle_reg, out_handle_next;
    logic [UNIT_W-1:0]      out_unit_reg, out_unit_next;
    logic                   out_active_reg, out_active_next;
    logic                   out_last_reg, out_last_next;

    logic                   out_free;
    logic                   cur_vld;
    logic                   hit;
    logic                   hmatch;
    logic                   step;
    logic [HANDLE_BITS-1:0] handle_inc;
    logic [HANDLE_BITS-1:0] handle_new;

    assign out_free   = !out_valid_reg || res.ready;
    assign cur_vld    = vld_reg[idx_reg];
    assign hit        = (!rdata_reg.at_start && rdata_reg.unit == prev_reg) ||
                        (rdata_reg.at_start && rdata_reg.unit == nxt_reg);
    assign hmatch     = 32'(rdata_reg.handle) == 32'(tid_reg);
    assign handle_inc = counter_reg + HANDLE_BITS'(1);
    assign handle_new = (handle_inc == '0) ? HANDLE_BITS'(1) : handle_inc;

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.kind       = out_kind_reg;
    assign res.handle_id  = out_handle_reg;
    assign res.fired_unit = out_unit_reg;
    assign res.active     = out_active_reg;
    assign res.last       = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        vld_next        = vld_reg;
        counter_next    = counter_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        unit_next       = unit_reg;
        loop_next       = loop_reg;
        at_start_next   = at_start_reg;
        tid_next        = tid_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_kind_next   = out_kind_reg;
        out_handle_next = out_handle_reg;
        out_unit_next   = out_unit_reg;
        out_active_next = out_active_reg;
        out_last_next   = out_last_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = rdata_reg;
        raddr           = idx_reg;
        step            = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                raddr = '0;
                if (cmd.valid)
                begin
                    mode_next     = mode_t'(cmd.mode);
                    count_next    = cmd.turn_count;
                    unit_next     = UNIT_BITS'(cmd.unit_id);
                    loop_next     = cmd.loop_flag;
                    at_start_next = cmd.fire_at_start;
                    tid_next      = cmd.timer_id;
                    prev_next     = UNIT_BITS'(cmd.previous_unit);
                    nxt_next      = UNIT_BITS'(cmd.next_unit);
                    idx_next      = '0;
                    found_next    = 1'b0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                unique case (mode_reg)
                    MODE_SET:
                    begin
                        if (!found_reg && !cur_vld)
                        begin
                            found_next = 1'b1;
                            slot_next  = idx_reg;
                        end
                    end
                    MODE_CLEAR, MODE_QUERY:
                    begin
                        if (!found_reg && cur_vld && hmatch)
                        begin
                            found_next = 1'b1;
                            if (mode_reg == MODE_CLEAR)
                            begin
                                vld_next[idx_reg] = 1'b0;
                            end
                        end
                    end
                    MODE_TURN:
                    begin
                        if (cur_vld && hit)
                        begin
                            if (rdata_reg.left > COUNT_W'(1))
                            begin
                                we         = 1'b1;
                                wdata.left = rdata_reg.left - COUNT_W'(1);
                            end
                            else if (out_free)
                            begin
                                out_valid_next  = 1'b1;
                                out_kind_next   = KIND_FIRED;
                                out_handle_next = HANDLE_W'(rdata_reg.handle);
                                out_unit_next   = UNIT_W'(rdata_reg.unit);
                                out_active_next = 1'b0;
                                out_last_next   = 1'b0;
                                if (rdata_reg.looping)
                                begin
                                    we         = 1'b1;
                                    wdata.left = rdata_reg.period;
                                end
                                else
                                begin
                                    vld_next[idx_reg] = 1'b0;
                                end
                            end
                            else
                            begin
                                step = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        step = 1'b1;
                    end
                endcase

                if (step)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        raddr      = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        raddr    = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_FINISH:
            begin
                raddr = '0;
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = '0;
                    out_unit_next   = '0;
                    out_active_next = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                    unique case (mode_reg)
                        MODE_SET:
                        begin
                            if (found_reg)
                            begin
                                we                 = 1'b1;
                                waddr              = slot_reg;
                                wdata.handle       = handle_new;
                                wdata.unit         = unit_reg;
                                wdata.period       = count_reg;
                                wdata.left         = count_reg;
                                wdata.looping      = loop_reg;
                                wdata.at_start     = at_start_reg;
                                vld_next[slot_reg] = 1'b1;
                                counter_next       = handle_new;
                                out_kind_next      = KIND_ISSUED;
                                out_handle_next    = HANDLE_W'(handle_new);
                            end
                            else
                            begin
                                out_kind_next = KIND_FULL;
                            end
                        end
                        MODE_CLEAR, MODE_QUERY:
                        begin
                            out_kind_next   = KIND_ANSWER;
                            out_handle_next = tid_reg;
                            out_active_next = found_reg;
                        end
                        MODE_TURN:
                        begin
                            out_kind_next = KIND_DONE;
                        end
                        default:
                        begin
                            out_kind_next = KIND_DONE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            vld_reg       <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            vld_reg       <= vld_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        mode_reg       <= mode_next;
        count_reg      <= count_next;
        unit_reg       <= unit_next;
        loop_reg       <= loop_next;
        at_start_reg   <= at_start_next;
        tid_reg        <= tid_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        out_kind_reg   <= out_kind_next;
        out_handle_reg <= out_handle_next;
        out_unit_reg   <= out_unit_next;
        out_active_reg <= out_active_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // An issued handle is never zero when it fits the result field.
    a_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_ISSUED) |->
            ((HANDLE_BITS > HANDLE_W) || out_handle_reg != '0))
        else $error("issued handle is zero");

    // A full answer is only given when every slot is taken.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && mode_reg == MODE_SET && !found_reg) |-> (&vld_reg))
        else $error("table reported full with a free slot");

    // The finishing step posts a final result once the result register is free.
    a_finish_posts_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid_reg && out_last_reg))
        else $error("final result missing after finish");

    // A fired result is never the last result of its item.
    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_FIRED) |-> !out_last_reg)
        else $error("fired result marked last");

    // An accepted item starts a walk of the table from its first slot.
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && state_reg == ST_IDLE) |=> (state_reg == ST_SCAN && idx_reg == '0))
        else $error("accepted item did not start a table walk");

endmodule

`default_nettype wire
